[hw/rtl/ibt_pkg.sv]
// Shared types and constants of the interval booking table.
// No dependencies; every other file of the block depends on this package.
package ibt_pkg;

   localparam int ENTRIES   = 1024;
   localparam int TIME_BITS = 32;
   localparam int IDX_BITS  = $clog2(ENTRIES);
   localparam int CNT_BITS  = $clog2(ENTRIES + 1);

   typedef logic [TIME_BITS-1:0] time_type;
   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic [1:0] {
      ST_BOOKED  = 2'd0,
      ST_OVERLAP = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DECIDE
   } seq_state_type;

   typedef struct packed {
      time_type slot_start;
      time_type slot_end;
   } slot_type;

   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      slot_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } mem_cmd_type;

endpackage

[hw/rtl/ibt_if.sv]
// Valid/ready channel interfaces of the interval booking table.
// Depends on ibt_pkg for the payload widths.
interface ibt_req_if;
   logic                          valid;
   logic                          ready;
   logic [ibt_pkg::TIME_BITS-1:0] start_time;
   logic [ibt_pkg::TIME_BITS-1:0] end_time;

   modport source (output valid, output start_time, output end_time, input ready);
   modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

interface ibt_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;

   modport source (output valid, output status, input ready);
   modport sink   (input valid, input status, output ready);
endinterface

[hw/rtl/ibt_slot_mem.sv]
// Slot storage: one write port, one read port with registered read data.
// Depends on ibt_pkg.
module ibt_slot_mem (
   input  logic                 clock,
   input  ibt_pkg::mem_cmd_type mem_cmd,
   output ibt_pkg::slot_type    rd_data
);
   import ibt_pkg::*;

   slot_type slot_mem [ENTRIES];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         slot_mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= slot_mem[mem_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ibt_overlap_cmp.sv]
// Shared overlap comparator: one stored slot against the pending request.
// Depends on ibt_pkg.
module ibt_overlap_cmp (
   input  ibt_pkg::slot_type slot,
   input  ibt_pkg::time_type req_start,
   input  ibt_pkg::time_type req_end,
   output logic              hit
);
   import ibt_pkg::*;

   // half-open intervals: touching ends do not overlap
   assign hit = (slot.slot_start < req_end) && (slot.slot_end > req_start);

endmodule

[hw/rtl/ibt_seq.sv]
// Sequencer: takes a request, scans the valid slots one per cycle through
// the shared comparator, then books or rejects. Depends on ibt_pkg, ibt_if.
module ibt_seq (
   input  logic                 clock,
   input  logic                 reset,
   ibt_req_if.sink              req_bus,
   ibt_rsp_if.source            rsp_bus,
   input  logic                 cmp_hit,
   output ibt_pkg::time_type    cur_start,
   output ibt_pkg::time_type    cur_end,
   output ibt_pkg::mem_cmd_type mem_cmd
);
   import ibt_pkg::*;

   seq_state_type state_ff, state_in;
   time_type      start_ff, start_in;
   time_type      end_ff, end_in;
   logic          invalid_ff, invalid_in;
   logic          hit_ff, hit_in;
   logic          pend_ff, pend_in;
   cnt_type       idx_ff, idx_in;
   cnt_type       count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    status_ff, status_in;

   logic       accept;
   logic       req_bad;
   logic       scan_done;
   logic       done;
   logic       booked;
   status_type verdict;

   assign accept    = req_bus.valid && req_bus.ready;
   assign req_bad   = req_bus.start_time >= req_bus.end_time;
   assign scan_done = (idx_ff == count_ff) && !pend_ff;
   // result register free (or being emptied this cycle)
   assign done      = (state_ff == SEQ_DECIDE) && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      if (invalid_ff) begin
         verdict = ST_INVALID;
      end else if (hit_ff) begin
         verdict = ST_OVERLAP;
      end else if (count_ff == CNT_BITS'(ENTRIES)) begin
         verdict = ST_FULL;
      end else begin
         verdict = ST_BOOKED;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = req_bad ? SEQ_DECIDE : SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            if (scan_done) begin
               state_in = SEQ_DECIDE;
            end
         end
         SEQ_DECIDE: begin
            if (done) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_bus.ready = (state_ff == SEQ_IDLE);
      booked        = done && (verdict == ST_BOOKED);

      mem_cmd.rd_en           = (state_ff == SEQ_SCAN) && (idx_ff != count_ff);
      mem_cmd.rd_addr         = idx_ff[IDX_BITS-1:0];
      mem_cmd.wr_en           = booked;
      mem_cmd.wr_addr         = count_ff[IDX_BITS-1:0];
      mem_cmd.wr_data.slot_start = start_ff;
      mem_cmd.wr_data.slot_end   = end_ff;

      start_in   = accept ? req_bus.start_time : start_ff;
      end_in     = accept ? req_bus.end_time : end_ff;
      invalid_in = accept ? req_bad : invalid_ff;
      idx_in     = accept ? '0 : (mem_cmd.rd_en ? idx_ff + 1'b1 : idx_ff);
      pend_in    = mem_cmd.rd_en;
      if (accept) begin
         hit_in = 1'b0;
      end else begin
         hit_in = hit_ff || (pend_ff && cmp_hit);
      end
      count_in = booked ? count_ff + 1'b1 : count_ff;

      if (done) begin
         rsp_valid_in = 1'b1;
         status_in    = verdict;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
         status_in    = status_ff;
      end

      rsp_bus.valid  = rsp_valid_ff;
      rsp_bus.status = status_ff;
      cur_start      = start_ff;
      cur_end        = end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         hit_ff       <= hit_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      end_ff     <= end_in;
      invalid_ff <= invalid_in;
      status_ff  <= status_in;
   end

endmodule

[hw/rtl/interval_booking_table.sv]
// Interval booking table, top level.
// Depends on ibt_pkg, ibt_if, ibt_slot_mem, ibt_overlap_cmp, ibt_seq.
// Usage:
//   req_bus carries one booking request per beat: start_time (inclusive)
//   and end_time (exclusive). rsp_bus returns one status beat per request:
//   0 booked, 1 overlaps a stored interval, 2 table full, 3 empty interval.
//   A booked interval is appended to the slot memory; others change nothing.
// Sequence:
//   From its beat, a request runs through the reads of the stored slots,
//   a compare of the last slot, a step to leave the scan and a decide step,
//   then its status beat. An empty table does no reads and no compare, and
//   an empty interval skips the scan. req_bus.ready is high only while no
//   request is in progress, so the next request is taken at best as the
//   status goes out: no new request is taken before the last is decided.
// Reset:
//   Synchronous reset empties the table (fill count to zero); the slot
//   memory itself is not cleared and needs no clearing pass.
// Backpressure:
//   The status waits in an output register while rsp_bus.ready is low; the
//   next request may already be taken and scanned, then holds until it frees.
module interval_booking_table (
   input  logic      clock,
   input  logic      reset,
   ibt_req_if.sink   req_bus,
   ibt_rsp_if.source rsp_bus
);
   import ibt_pkg::*;

   mem_cmd_type mem_cmd;
   slot_type    rd_slot;
   time_type    cur_start;
   time_type    cur_end;
   logic        cmp_hit;

   ibt_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .cmp_hit   (cmp_hit),
      .cur_start (cur_start),
      .cur_end   (cur_end),
      .mem_cmd   (mem_cmd)
   );

   ibt_slot_mem u_mem (
      .clock   (clock),
      .mem_cmd (mem_cmd),
      .rd_data (rd_slot)
   );

   ibt_overlap_cmp u_cmp (
      .slot      (rd_slot),
      .req_start (cur_start),
      .req_end   (cur_end),
      .hit       (cmp_hit)
   );

`ifndef SYNTHESIS
   // a slot write is the booking itself: the booked status follows
   a_write_booked: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.wr_en |=> (rsp_bus.valid && rsp_bus.status == ST_BOOKED))
      else $error("slot write without booked status");

   // scan and append never share the memory in one cycle
   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_cmd.rd_en && mem_cmd.wr_en))
      else $error("slot read and write in the same cycle");

   // one request in progress at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while another is in progress");
`endif

endmodule
